@@ hw/rtl/tsae_pkg.sv @@
// ----------------------------------------------------------------------------
// tsae_pkg: shared types and helpers for the two-shot alpha extractor
// Holds widths, pipeline depth, the restoring divide step and sideband types.
// ----------------------------------------------------------------------------
`default_nettype none

package tsae_pkg;

  localparam int unsigned PixW         = 8;
  localparam int unsigned NumW         = 2 * PixW;
  localparam int unsigned DivStages    = 4;
  localparam int unsigned BitsPerStage = PixW / DivStages;

  localparam logic [PixW-1:0] FullScale = 8'd255;

  typedef struct packed {
    logic [PixW-1:0] rem;
    logic [PixW-1:0] low;
    logic [PixW-1:0] quo;
  } div_state_t;

  typedef struct packed {
    logic            same;
    logic            zero;
    logic [PixW-1:0] alpha;
    logic [PixW-1:0] red;
    logic [PixW-1:0] green;
    logic [PixW-1:0] blue;
  } side_t;

  // ch * 255 as (ch << 8) - ch
  function automatic logic [NumW-1:0] scale_full(input logic [PixW-1:0] ch);
    scale_full = {ch, {PixW{1'b0}}} - {{PixW{1'b0}}, ch};
  endfunction

  // initial divider state, the high half is already below the divisor
  function automatic div_state_t div_init(input logic [NumW-1:0] num);
    div_state_t s;
    s.rem = num[NumW-1:PixW];
    s.low = num[PixW-1:0];
    s.quo = '0;
    div_init = s;
  endfunction

  // one restoring divide step, one quotient bit
  function automatic div_state_t div_step(input div_state_t s,
                                          input logic [PixW-1:0] den);
    logic [PixW:0] t;
    logic [PixW:0] d;
    div_state_t    n;
    t     = {s.rem, s.low[PixW-1]};
    d     = {1'b0, den};
    n.low = {s.low[PixW-2:0], 1'b0};
    if (t >= d) begin
      n.rem = PixW'(t - d);
      n.quo = {s.quo[PixW-2:0], 1'b1};
    end else begin
      n.rem = t[PixW-1:0];
      n.quo = {s.quo[PixW-2:0], 1'b0};
    end
    div_step = n;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/tsae_lane.sv @@
// ----------------------------------------------------------------------------
// tsae_lane: pipelined un-premultiply divider for one color channel
// Restoring division of ch*255 by alpha, two quotient bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tsae_lane (
  input  wire logic                      clk_i,
  input  wire logic [tsae_pkg::NumW-1:0] num_i,
  input  wire logic [tsae_pkg::PixW-1:0] den_i,
  output logic      [tsae_pkg::PixW-1:0] quo_o
);

  tsae_pkg::div_state_t st_q  [tsae_pkg::DivStages];
  tsae_pkg::div_state_t st_d  [tsae_pkg::DivStages];
  logic [tsae_pkg::PixW-1:0] den_q [tsae_pkg::DivStages];

  for (genvar k = 0; k < tsae_pkg::DivStages; k++) begin : g_stage
    tsae_pkg::div_state_t     s_in;
    logic [tsae_pkg::PixW-1:0] den_in;

    if (k == 0) begin : g_first
      assign s_in   = tsae_pkg::div_init(num_i);
      assign den_in = den_i;
    end else begin : g_next
      assign s_in   = st_q[k-1];
      assign den_in = den_q[k-1];
    end

    always_comb begin
      st_d[k] = s_in;
      for (int unsigned b = 0; b < tsae_pkg::BitsPerStage; b++) begin
        st_d[k] = tsae_pkg::div_step(st_d[k], den_in);
      end
    end

    always_ff @(posedge clk_i) begin
      st_q[k]  <= st_d[k];
      den_q[k] <= den_in;
    end
  end

  assign quo_o = st_q[tsae_pkg::DivStages-1].quo;

endmodule

`default_nettype wire

@@ hw/rtl/tsae_merge.sv @@
// ----------------------------------------------------------------------------
// tsae_merge: combines the lane quotients with the pixel sideband
// Selects opaque pass-through, all-zero or un-premultiplied color.
// ----------------------------------------------------------------------------
`default_nettype none

module tsae_merge (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      valid_i,
  input  wire tsae_pkg::side_t           side_i,
  input  wire logic [tsae_pkg::PixW-1:0] quo_red_i,
  input  wire logic [tsae_pkg::PixW-1:0] quo_green_i,
  input  wire logic [tsae_pkg::PixW-1:0] quo_blue_i,
  output logic                           valid_o,
  output logic      [tsae_pkg::PixW-1:0] red_o,
  output logic      [tsae_pkg::PixW-1:0] green_o,
  output logic      [tsae_pkg::PixW-1:0] blue_o,
  output logic      [tsae_pkg::PixW-1:0] alpha_o
);

  logic                      valid_q;
  logic [tsae_pkg::PixW-1:0] red_d, green_d, blue_d, alpha_d;
  logic [tsae_pkg::PixW-1:0] red_q, green_q, blue_q, alpha_q;

  always_comb begin
    if (side_i.same) begin
      red_d   = side_i.red;
      green_d = side_i.green;
      blue_d  = side_i.blue;
      alpha_d = tsae_pkg::FullScale;
    end else if (side_i.zero) begin
      red_d   = '0;
      green_d = '0;
      blue_d  = '0;
      alpha_d = '0;
    end else begin
      red_d   = quo_red_i;
      green_d = quo_green_i;
      blue_d  = quo_blue_i;
      alpha_d = side_i.alpha;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    red_q   <= red_d;
    green_q <= green_d;
    blue_q  <= blue_d;
    alpha_q <= alpha_d;
  end

  assign valid_o = valid_q;
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;
  assign alpha_o = alpha_q;

endmodule

`default_nettype wire

@@ hw/rtl/two_shot_alpha_extract.sv @@
// ----------------------------------------------------------------------------
// two_shot_alpha_extract: color and opacity from two shots of one pixel
// Pipelined extractor with one divider lane per color channel.
//
// Usage:
//   A request is taken at each rising edge where start is high and busy is
//   low. busy is always low, so a new pixel pair may come every cycle.
//   Each request gives exactly one result: strobe_o is high for one cycle
//   with out_red_o, out_green_o, out_blue_o and out_alpha_o valid in it.
//   Pipeline: one stage for compare, max and scaling, four divider
//   stages of two quotient bits each, one merge stage.
//   Throughput: one pixel per cycle; the divider lanes are fully pipelined.
//   Results leave in request order. The receiver cannot stall the block,
//   and no pushback is needed since nothing is buffered beyond the pipe.
//   Reset clears all valid flags; requests in flight are dropped and no
//   strobe appears until a new request has passed through.
// ----------------------------------------------------------------------------
`default_nettype none

module two_shot_alpha_extract (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [tsae_pkg::PixW-1:0] first_red_i,
  input  wire logic [tsae_pkg::PixW-1:0] first_green_i,
  input  wire logic [tsae_pkg::PixW-1:0] first_blue_i,
  input  wire logic [tsae_pkg::PixW-1:0] second_red_i,
  input  wire logic [tsae_pkg::PixW-1:0] second_green_i,
  input  wire logic [tsae_pkg::PixW-1:0] second_blue_i,
  output logic                           strobe_o,
  output logic      [tsae_pkg::PixW-1:0] out_red_o,
  output logic      [tsae_pkg::PixW-1:0] out_green_o,
  output logic      [tsae_pkg::PixW-1:0] out_blue_o,
  output logic      [tsae_pkg::PixW-1:0] out_alpha_o
);

  logic                      req;
  logic [tsae_pkg::PixW-1:0] alpha;
  tsae_pkg::side_t           side_d;

  logic                      pre_vld_q;
  tsae_pkg::side_t           pre_side_q;
  logic [tsae_pkg::NumW-1:0] num_r_q, num_g_q, num_b_q;

  logic            vld_q  [tsae_pkg::DivStages];
  tsae_pkg::side_t side_q [tsae_pkg::DivStages];

  logic [tsae_pkg::PixW-1:0] quo_r, quo_g, quo_b;

  assign busy = 1'b0;
  assign req  = start && !busy;

  // greatest channel of the second shot
  always_comb begin
    alpha = second_red_i;
    if (second_green_i > alpha) begin
      alpha = second_green_i;
    end
    if (second_blue_i > alpha) begin
      alpha = second_blue_i;
    end
  end

  always_comb begin
    side_d.same  = (first_red_i == second_red_i) && (first_green_i == second_green_i)
                   && (first_blue_i == second_blue_i);
    side_d.zero  = (alpha == '0);
    side_d.alpha = alpha;
    side_d.red   = first_red_i;
    side_d.green = first_green_i;
    side_d.blue  = first_blue_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_vld_q <= 1'b0;
      for (int unsigned k = 0; k < tsae_pkg::DivStages; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else begin
      pre_vld_q <= req;
      vld_q[0]  <= pre_vld_q;
      for (int unsigned k = 1; k < tsae_pkg::DivStages; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pre_side_q <= side_d;
    num_r_q    <= tsae_pkg::scale_full(second_red_i);
    num_g_q    <= tsae_pkg::scale_full(second_green_i);
    num_b_q    <= tsae_pkg::scale_full(second_blue_i);
    side_q[0]  <= pre_side_q;
    for (int unsigned k = 1; k < tsae_pkg::DivStages; k++) begin
      side_q[k] <= side_q[k-1];
    end
  end

  tsae_lane u_lane_red (
    .clk_i (clk_i),
    .num_i (num_r_q),
    .den_i (pre_side_q.alpha),
    .quo_o (quo_r)
  );

  tsae_lane u_lane_green (
    .clk_i (clk_i),
    .num_i (num_g_q),
    .den_i (pre_side_q.alpha),
    .quo_o (quo_g)
  );

  tsae_lane u_lane_blue (
    .clk_i (clk_i),
    .num_i (num_b_q),
    .den_i (pre_side_q.alpha),
    .quo_o (quo_b)
  );

  tsae_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (vld_q[tsae_pkg::DivStages-1]),
    .side_i      (side_q[tsae_pkg::DivStages-1]),
    .quo_red_i   (quo_r),
    .quo_green_i (quo_g),
    .quo_blue_i  (quo_b),
    .valid_o     (strobe_o),
    .red_o       (out_red_o),
    .green_o     (out_green_o),
    .blue_o      (out_blue_o),
    .alpha_o     (out_alpha_o)
  );

  // every request gives one strobe after the fixed latency
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req |-> ##6 strobe_o)
    else $error("missing result strobe");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req |-> ##6 !strobe_o)
    else $error("result strobe without request");

  // zero alpha only comes with an all-black result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && out_alpha_o == '0) |->
      (out_red_o == '0 && out_green_o == '0 && out_blue_o == '0))
    else $error("color nonzero at zero alpha");

  // an agreeing pair passes opaque, with red and blue checked unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req && side_d.same) |-> ##6 (out_alpha_o == tsae_pkg::FullScale
      && out_red_o == $past(first_red_i, 6) && out_blue_o == $past(first_blue_i, 6)))
    else $error("agreeing pixel not passed through");

endmodule

`default_nettype wire
